/* rtl/hbs_pkg.sv */
package hbs_pkg;

    localparam int MAX_SIDE    = 512;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int POS_W       = 26;
    localparam int HEIGHT_W    = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPACE_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_CHECK,
        ST_INDEX,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_CAP,
        ST_ROWS,
        ST_COLS,
        ST_SCALE
    } eng_state_t;

    typedef struct packed {
        logic [24:0] space_size;
        logic [23:0] inv_step_x;
        logic [23:0] inv_step_z;
        logic [15:0] height_scale;
        logic [9:0]  grid_width;
        logic [9:0]  grid_length;
    } cfg_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [SAMPLE_W-1:0] data;
    } st_wr_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
    } st_rd_t;

    typedef struct packed {
        logic                valid;
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } res_t;

endpackage

/* rtl/hbs_store.sv */
module hbs_store (
    input  logic                              aclk,
    input  hbs_pkg::st_wr_t                   wr,
    input  hbs_pkg::st_rd_t                   rd,
    output logic [hbs_pkg::SAMPLE_W-1:0]      rd_data
);
    import hbs_pkg::*;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/hbs_engine.sv */
module hbs_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hbs_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_op,
    input  logic [hbs_pkg::STORE_AW-1:0]      in_address,
    input  logic [hbs_pkg::SAMPLE_W-1:0]      in_sample,
    input  logic signed [hbs_pkg::POS_W-1:0]  in_pos_x,
    input  logic signed [hbs_pkg::POS_W-1:0]  in_pos_z,
    input  logic                              out_busy,
    output hbs_pkg::res_t                     res,
    output hbs_pkg::st_wr_t                   st_wr,
    output hbs_pkg::st_rd_t                   st_rd,
    input  logic [hbs_pkg::SAMPLE_W-1:0]      rd_data
);
    import hbs_pkg::*;

    eng_state_t state_reg, state_next;

    logic signed [26:0] dx_reg, dx_next, dz_reg, dz_next;
    logic [33:0]        gx_reg, gx_next, gz_reg, gz_next;
    logic               negx_reg, negx_next, negz_reg, negz_next;
    logic [9:0]         x_reg, x_next, z_reg, z_next;
    logic [9:0]         x1_reg, x1_next, z1_reg, z1_next;
    logic [7:0]         fx_reg, fx_next, fz_reg, fz_next;
    logic [19:0]        row0_reg, row0_next, row1_reg, row1_next;
    logic [SAMPLE_W-1:0] bl_reg, bl_next, br_reg, br_next;
    logic [SAMPLE_W-1:0] tl_reg, tl_next, tr_reg, tr_next;
    logic [24:0]        bot_reg, bot_next, top_reg, top_next;
    logic [31:0]        h_reg, h_next;
    logic               inr_reg, inr_next;

    logic [49:0] gx_prod, gz_prod;
    logic [17:0] lim_x, lim_z;
    logic        outside;
    logic [10:0] xp1, zp1;
    logic [8:0]  wfx, wfz;
    logic [32:0] h_sum;
    logic [47:0] r_prod;
    logic [19:0] addr_sum;

    assign gx_prod  = dx_reg[25:0] * cfg.inv_step_x;
    assign gz_prod  = dz_reg[25:0] * cfg.inv_step_z;
    assign lim_x    = {cfg.grid_width, 8'd0};
    assign lim_z    = {cfg.grid_length, 8'd0};
    assign outside  = negx_reg || negz_reg
                   || (gx_reg >= {16'd0, lim_x}) || (gz_reg >= {16'd0, lim_z});
    assign xp1      = {1'b0, gx_reg[17:8]} + 11'd1;
    assign zp1      = {1'b0, gz_reg[17:8]} + 11'd1;
    assign wfx      = 9'd256 - {1'b0, fx_reg};
    assign wfz      = 9'd256 - {1'b0, fz_reg};
    assign h_sum    = bot_reg * wfz + top_reg * {1'b0, fz_reg};
    assign r_prod   = h_reg * cfg.height_scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg   <= dx_next;
        dz_reg   <= dz_next;
        gx_reg   <= gx_next;
        gz_reg   <= gz_next;
        negx_reg <= negx_next;
        negz_reg <= negz_next;
        x_reg    <= x_next;
        z_reg    <= z_next;
        x1_reg   <= x1_next;
        z1_reg   <= z1_next;
        fx_reg   <= fx_next;
        fz_reg   <= fz_next;
        row0_reg <= row0_next;
        row1_reg <= row1_next;
        bl_reg   <= bl_next;
        br_reg   <= br_next;
        tl_reg   <= tl_next;
        tr_reg   <= tr_next;
        bot_reg  <= bot_next;
        top_reg  <= top_next;
        h_reg    <= h_next;
        inr_reg  <= inr_next;
    end

    always_comb begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dz_next    = dz_reg;
        gx_next    = gx_reg;
        gz_next    = gz_reg;
        negx_next  = negx_reg;
        negz_next  = negz_reg;
        x_next     = x_reg;
        z_next     = z_reg;
        x1_next    = x1_reg;
        z1_next    = z1_reg;
        fx_next    = fx_reg;
        fz_next    = fz_reg;
        row0_next  = row0_reg;
        row1_next  = row1_reg;
        bl_next    = bl_reg;
        br_next    = br_reg;
        tl_next    = tl_reg;
        tr_next    = tr_reg;
        bot_next   = bot_reg;
        top_next   = top_reg;
        h_next     = h_reg;
        inr_next   = inr_reg;
        in_ready   = 1'b0;
        addr_sum   = 20'd0;
        st_wr      = '0;
        st_rd      = '0;
        res        = '0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                dx_next  = $signed({2'b00, cfg.space_size}) - $signed({in_pos_x[25], in_pos_x});
                dz_next  = $signed({2'b00, cfg.space_size}) - $signed({in_pos_z[25], in_pos_z});
                if (in_valid) begin
                    if (in_op == OP_QUERY) begin
                        state_next = ST_MAP;
                    end else begin
                        st_wr.en   = 1'b1;
                        st_wr.addr = in_address;
                        st_wr.data = in_sample;
                    end
                end
            end
            ST_MAP: begin
                gx_next    = gx_prod[49:16];
                gz_next    = gz_prod[49:16];
                negx_next  = dx_reg[26];
                negz_next  = dz_reg[26];
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                x_next  = gx_reg[17:8];
                z_next  = gz_reg[17:8];
                fx_next = gx_reg[7:0];
                fz_next = gz_reg[7:0];
                x1_next = (xp1 < {1'b0, cfg.grid_width}) ? xp1[9:0] : cfg.grid_width - 10'd1;
                z1_next = (zp1 < {1'b0, cfg.grid_length}) ? zp1[9:0] : cfg.grid_length - 10'd1;
                if (outside) begin
                    h_next     = 32'd0;
                    inr_next   = 1'b0;
                    state_next = ST_SCALE;
                end else begin
                    inr_next   = 1'b1;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: begin
                row0_next  = z_reg * cfg.grid_width;
                row1_next  = z1_reg * cfg.grid_width;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                addr_sum   = {10'd0, x_reg} + row0_reg;
                st_rd.en   = 1'b1;
                st_rd.addr = addr_sum[STORE_AW-1:0];
                state_next = ST_RD1;
            end
            ST_RD1: begin
                addr_sum   = {10'd0, x1_reg} + row0_reg;
                st_rd.en   = 1'b1;
                st_rd.addr = addr_sum[STORE_AW-1:0];
                bl_next    = rd_data;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                addr_sum   = {10'd0, x_reg} + row1_reg;
                st_rd.en   = 1'b1;
                st_rd.addr = addr_sum[STORE_AW-1:0];
                br_next    = rd_data;
                state_next = ST_RD3;
            end
            ST_RD3: begin
                addr_sum   = {10'd0, x1_reg} + row1_reg;
                st_rd.en   = 1'b1;
                st_rd.addr = addr_sum[STORE_AW-1:0];
                tl_next    = rd_data;
                state_next = ST_CAP;
            end
            ST_CAP: begin
                tr_next    = rd_data;
                state_next = ST_ROWS;
            end
            ST_ROWS: begin
                bot_next   = bl_reg * wfx + br_reg * {1'b0, fx_reg};
                top_next   = tl_reg * wfx + tr_reg * {1'b0, fx_reg};
                state_next = ST_COLS;
            end
            ST_COLS: begin
                h_next     = h_sum[31:0];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (!out_busy) begin
                    res.valid    = 1'b1;
                    res.height   = r_prod[47:16];
                    res.in_range = inr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        st_wr.en |-> (state_reg == ST_IDLE))
        else $error("store write outside idle");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st_wr.en && st_rd.en))
        else $error("store read and write together");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.in_range) |-> (res.height == 32'd0))
        else $error("outside result not zero");

    a_result_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !out_busy)
        else $error("result issued while output register full");

    a_read_then_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD3) |=> (state_reg == ST_CAP))
        else $error("last read not followed by capture");

endmodule

/* rtl/heightmap_bilinear_sampler_core.sv */
// channel   | dir | tdata (low bit up)                          | tuser
// s_        | in  | address 18, sample 16, pos_x 26, pos_z 26   | operation
// m_        | out | terrain_height 32                           | in_range
// cfg_      | in  | cfg_wdata 25 bits, cfg_index 3 bits, cfg_we | -
//
// one item at a time through a height store with one write port and one registered read port
// a write is stored as it is accepted; a query outside the grid passes map, check and scale;
// one inside also passes index, four sequential store reads, capture and the row and column blends
// aresetn is synchronous; the store holds no reset and is valid once written
// a query waits in its last stage while the output register is full and m_tready is low
module heightmap_bilinear_sampler_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [87:0]                         s_tdata,  // address, sample, pos_x, pos_z
    input  logic [0:0]                          s_tuser,  // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // terrain_height
    output logic [0:0]                          m_tuser,  // in_range
    input  logic                                cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import hbs_pkg::*;

    cfg_t    cfg_reg;
    st_wr_t  st_wr;
    st_rd_t  st_rd;
    res_t    res;
    logic [SAMPLE_W-1:0] rd_data;
    logic    out_busy;

    logic                m_tvalid_reg;
    logic [HEIGHT_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.space_size   <= 25'd0;
            cfg_reg.inv_step_x   <= 24'd65536;
            cfg_reg.inv_step_z   <= 24'd65536;
            cfg_reg.height_scale <= 16'd256;
            cfg_reg.grid_width   <= 10'd256;
            cfg_reg.grid_length  <= 10'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SPACE_SIZE:   cfg_reg.space_size   <= cfg_wdata;
                REG_INV_STEP_X:   cfg_reg.inv_step_x   <= cfg_wdata[23:0];
                REG_INV_STEP_Z:   cfg_reg.inv_step_z   <= cfg_wdata[23:0];
                REG_HEIGHT_SCALE: cfg_reg.height_scale <= cfg_wdata[15:0];
                REG_GRID_WIDTH:   cfg_reg.grid_width   <= cfg_wdata[9:0];
                REG_GRID_LENGTH:  cfg_reg.grid_length  <= cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    hbs_store u_store (
        .aclk    (aclk),
        .wr      (st_wr),
        .rd      (st_rd),
        .rd_data (rd_data)
    );

    hbs_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[0]),
        .in_address (s_tdata[17:0]),
        .in_sample  (s_tdata[33:18]),
        .in_pos_x   (s_tdata[59:34]),
        .in_pos_z   (s_tdata[85:60]),
        .out_busy   (out_busy),
        .res        (res),
        .st_wr      (st_wr),
        .st_rd      (st_rd),
        .rd_data    (rd_data)
    );

    assign out_busy = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_tdata_reg <= res.height;
            m_tuser_reg <= res.in_range;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

/* bench/hbs_height_checker.sv */
module hbs_height_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [87:0]                    s_tdata,  // address, sample, pos_x, pos_z
    input  logic [0:0]                     s_tuser,  // operation
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [31:0]                    m_tdata,  // terrain_height
    input  logic [0:0]                     m_tuser,  // in_range
    input  logic                           cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);
    import hbs_pkg::*;

    localparam longint HEIGHT_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } height_answer_t;

    logic [SAMPLE_W-1:0] heights [STORE_DEPTH];
    height_answer_t      awaited [$];
    height_answer_t      oldest;

    logic [24:0] space_size;
    logic [23:0] inv_x;
    logic [23:0] inv_z;
    logic [15:0] v_scale;
    logic [9:0]  cols;
    logic [9:0]  rows;

    // world coordinate to q.8 grid coordinate, false when off the grid
    function automatic bit to_grid(input logic [POS_W-1:0] pos, input logic [23:0] inv,
                                   input logic [9:0] limit, output longint g);
        longint d;
        d = longint'(space_size) - longint'($signed(pos));
        g = 0;
        if (d < 0)
            return 1'b0;
        g = (d * longint'(inv)) >>> 16;
        return g < (longint'(limit) << 8);
    endfunction

    function automatic longint cell_at(input longint col, input longint row);
        return heights[(col + row * longint'(cols)) % STORE_DEPTH];
    endfunction

    function automatic height_answer_t sample_terrain(input logic [POS_W-1:0] px,
                                                      input logic [POS_W-1:0] pz);
        height_answer_t ans;
        longint gx, gz, x, z, x1, z1, fx, fz;
        longint top, bottom, blend, scaled;
        ans = '0;
        if (!to_grid(px, inv_x, cols, gx))
            return ans;
        if (!to_grid(pz, inv_z, rows, gz))
            return ans;
        x  = gx >>> 8;
        z  = gz >>> 8;
        fx = gx & 255;
        fz = gz & 255;
        x1 = (x + 1 < longint'(cols)) ? x + 1 : longint'(cols) - 1;
        z1 = (z + 1 < longint'(rows)) ? z + 1 : longint'(rows) - 1;
        top    = cell_at(x, z1) * (256 - fx) + cell_at(x1, z1) * fx;
        bottom = cell_at(x, z) * (256 - fx) + cell_at(x1, z) * fx;
        blend  = bottom * (256 - fz) + top * fz;
        scaled = (blend * longint'(v_scale)) >>> 16;
        if (scaled > HEIGHT_MAX)
            scaled = HEIGHT_MAX;
        ans.height   = scaled[31:0];
        ans.in_range = 1'b1;
        return ans;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            space_size = '0;
            inv_x      = 24'd65536;
            inv_z      = 24'd65536;
            v_scale    = 16'd256;
            cols       = 10'd256;
            rows       = 10'd256;
            awaited.delete();
            pending    = 0;
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SPACE_SIZE:   space_size = cfg_wdata[24:0];
                    REG_INV_STEP_X:   inv_x      = cfg_wdata[23:0];
                    REG_INV_STEP_Z:   inv_z      = cfg_wdata[23:0];
                    REG_HEIGHT_SCALE: v_scale    = cfg_wdata[15:0];
                    REG_GRID_WIDTH:   cols       = cfg_wdata[9:0];
                    REG_GRID_LENGTH:  rows       = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            // result first so a query taken at this edge never pairs with it
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    fail_count++;
                    $error("unexpected result: terrain_height %0h in_range %0b",
                           m_tdata, m_tuser[0]);
                end else begin
                    oldest = awaited.pop_front();
                    if (m_tdata !== oldest.height) begin
                        fail_count++;
                        $error("terrain_height: expected %0h, actual %0h",
                               oldest.height, m_tdata);
                    end
                    if (m_tuser[0] !== oldest.in_range) begin
                        fail_count++;
                        $error("in_range: expected %0b, actual %0b",
                               oldest.in_range, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_WRITE)
                    heights[s_tdata[17:0]] = s_tdata[33:18];
                else
                    awaited.insert(awaited.size(),
                                   sample_terrain(s_tdata[59:34], s_tdata[85:60]));
            end
            pending = awaited.size();
        end
    end

endmodule

/* bench/tb.sv */
module tb;
    import hbs_pkg::*;

    localparam int     DRAIN_CYCLES = 24;
    localparam int     HOLD_CYCLES  = 300;
    localparam longint TIMEOUT      = 2_000_000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [87:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned fail_count;
    int unsigned pending;

    bit written [STORE_DEPTH];

    logic [24:0] cur_space;
    logic [23:0] cur_invx;
    logic [23:0] cur_invz;
    logic [9:0]  cur_cols;
    logic [9:0]  cur_rows;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int writes_sent    = 0;
    int queries_sent   = 0;
    int queries_inside = 0;
    int settings_used  = 0;

    heightmap_bilinear_sampler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    hbs_height_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver, with a long hold-off whenever one is asked for
    always @(negedge aclk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic offer(input logic op, input logic [17:0] addr, input logic [15:0] smp,
                         input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pz, px, smp, addr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic plant(input logic [17:0] addr, input logic [15:0] smp);
        offer(OP_WRITE, addr, smp, POS_W'($urandom), POS_W'($urandom));
        written[addr] = 1'b1;
        writes_sent++;
    endtask

    task automatic fill_cell(input longint col, input longint row);
        longint idx;
        idx = (col + row * longint'(cur_cols)) % STORE_DEPTH;
        if (!written[idx])
            plant(18'(idx), 16'($urandom));
    endtask

    function automatic bit locate(input logic [POS_W-1:0] pos, input logic [23:0] inv,
                                  input logic [9:0] limit, output longint base,
                                  output longint next);
        longint d, g;
        d = longint'(cur_space) - longint'($signed(pos));
        g = (d * longint'(inv)) >>> 16;
        base = g >>> 8;
        next = (base + 1 < longint'(limit)) ? base + 1 : longint'(limit) - 1;
        return d >= 0 && g < (longint'(limit) << 8);
    endfunction

    // cells the query will blend are loaded first
    task automatic probe(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        longint x, x1, z, z1;
        if (locate(px, cur_invx, cur_cols, x, x1) && locate(pz, cur_invz, cur_rows, z, z1)) begin
            queries_inside++;
            fill_cell(x, z);
            fill_cell(x1, z);
            fill_cell(x, z1);
            fill_cell(x1, z1);
        end
        offer(OP_QUERY, 18'($urandom), 16'($urandom), px, pz);
        queries_sent++;
    endtask

    // position aimed at a grid coordinate, with edges and wild values mixed in
    function automatic logic [POS_W-1:0] aim(input logic [23:0] inv, input logic [9:0] limit);
        longint span, g, d, pos;
        span = longint'(limit) << 8;
        case ($urandom_range(9))
            0: g = span - 1;
            1: g = span;
            2: g = 0;
            3: return POS_W'($urandom);
            default: g = (span > 0) ? longint'($urandom_range(32'(span - 1))) : 0;
        endcase
        if (g < 0)
            g = 0;
        if (inv == 0)
            d = longint'($urandom_range(4095));
        else
            d = ((g << 16) + longint'(inv) - 1) / longint'(inv);
        pos = longint'(cur_space) - d;
        if (pos < -(longint'(1) << 25) || pos >= (longint'(1) << 25))
            return POS_W'($urandom);
        return POS_W'(pos);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [24:0] space, input logic [23:0] invx,
                                  input logic [23:0] invz, input logic [15:0] scale,
                                  input logic [9:0] cols, input logic [9:0] rows);
        settle();
        write_reg(REG_SPACE_SIZE, CFG_DATA_W'(space));
        write_reg(REG_INV_STEP_X, CFG_DATA_W'(invx));
        write_reg(REG_INV_STEP_Z, CFG_DATA_W'(invz));
        write_reg(REG_HEIGHT_SCALE, CFG_DATA_W'(scale));
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(cols));
        write_reg(REG_GRID_LENGTH, CFG_DATA_W'(rows));
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_space = space;
        cur_invx  = invx;
        cur_invz  = invz;
        cur_cols  = cols;
        cur_rows  = rows;
        settings_used++;
    endtask

    task automatic run_phase(input logic [24:0] space, input logic [23:0] invx,
                             input logic [23:0] invz, input logic [15:0] scale,
                             input logic [9:0] cols, input logic [9:0] rows,
                             input int items, input int send_pct, input int recv_pct,
                             input bit squeeze);
        logic [17:0] addr;
        apply_settings(space, invx, invz, scale, cols, rows);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < items; i++) begin
            if (squeeze && i == items / 3)
                hold_asked++;
            if ($urandom_range(99) < 70) begin
                probe(aim(invx, cols), aim(invz, rows));
            end else begin
                addr = 18'($urandom);
                plant(addr, 16'($urandom));
            end
        end
    endtask

    task automatic directed_part();
        logic [15:0] ramp [12];
        ramp = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 16'hFFFF, 16'hFFFF,
                 16'h0001, 16'h7FFF, 16'h00FF, 16'hFF00, 16'hFFFF, 16'hABCD};
        apply_settings(25'h0001000, 24'h010000, 24'h010000, 16'h0100, 10'd4, 10'd3);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 12; i++)
            plant(18'(i), ramp[i]);
        probe(26'd4096, 26'd4096);
        probe(26'(4096 - 3 * 256), 26'd4096);
        probe(26'(4096 - 1023), 26'(4096 - 767));
        probe(26'(4096 - 384), 26'(4096 - 320));
        probe(26'(4096 - 1024), 26'd4096);
        probe(26'd4096, 26'(4096 - 768));
        probe(26'd4097, 26'd4096);
        probe(26'h1FFFFFF, 26'd4096);
        probe(26'h2000000, 26'd4096);
        probe(26'd4096, 26'h2000000);
    endtask

    initial begin
        #(TIMEOUT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_part();
        run_phase(25'h0008000, 24'h020000, 24'h008000, 16'h0180, 10'd8, 10'd6,
                  40, 0, 0, 1'b0);
        run_phase(25'h0000000, 24'h010000, 24'h010000, 16'hFFFF, 10'd2, 10'd2,
                  40, 80, 0, 1'b0);
        run_phase(25'h1FFFFFF, 24'hFFFFFF, 24'h000100, 16'h0001, 10'd512, 10'd512,
                  40, 0, 80, 1'b0);
        // one column only: both horizontal neighbours are the same sample
        run_phase(25'h0010000, 24'h000000, 24'h018000, 16'hFFFF, 10'd1, 10'd5,
                  30, 9, 9, 1'b0);
        // zero width: nothing lands on the grid
        run_phase(25'h0000000, 24'h010000, 24'h000001, 16'h0100, 10'd0, 10'd512,
                  20, 80, 80, 1'b0);
        run_phase(25'h0400000, 24'h00C000, 24'h014000, 16'h0321, 10'd37, 10'd29,
                  60, 0, 0, 1'b1);
        run_phase(25'($urandom), 24'($urandom_range(24'h030000, 24'h002000)),
                  24'($urandom_range(24'h030000, 24'h002000)), 16'($urandom),
                  10'($urandom_range(20, 2)), 10'($urandom_range(20, 2)),
                  50, 9, 9, 1'b0);

        settle();
        $display("covered %0d sample writes and %0d queries, %0d of them on the grid,",
                 writes_sent, queries_sent, queries_inside);
        $display("over %0d register settings with idle, stall and hold-off phases",
                 settings_used);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
